// ----- sv/pfba_pkg.sv -----
// pfba_pkg: constants, codes and shared types of the page frame bitmap allocator
// no dependencies; every other file depends on this package
`default_nettype none
package pfba_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int BIT_AW       = $clog2(WORD_BITS);
  localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW      = $clog2(BITMAP_WORDS);
  localparam int WCNT_W       = WORD_AW + 1;
  localparam int FRAME_W      = 12;
  localparam int CFG_W        = 13;
  localparam int APB_DW       = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = PADDR_W - 2;

  localparam logic [CFG_W-1:0]     FRAMES_RESET      = CFG_W'(4096);
  localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = REG_IDX_W'(0);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } ram_req_t;

endpackage
`default_nettype wire

// ----- sv/pfba_if.sv -----
// pfba_in_if / pfba_out_if: valid/ready channels carrying request and response beats
// depends on pfba_pkg for field widths
`default_nettype none
interface pfba_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [pfba_pkg::FRAME_W-1:0]  entry_frame_in;
  logic                          kernel_page;
  logic                          writable_request;

  modport source (output valid, operation, entry_frame_in, kernel_page, writable_request,
                  input ready);
  modport sink (input valid, operation, entry_frame_in, kernel_page, writable_request,
                output ready);
endinterface

interface pfba_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfba_pkg::FRAME_W-1:0]  entry_frame_out;
  logic                          present_bit;
  logic                          writable_bit;
  logic                          user_bit;
  logic                          entry_changed;
  logic                          out_of_frames;

  modport source (output valid, entry_frame_out, present_bit, writable_bit, user_bit,
                  entry_changed, out_of_frames, input ready);
  modport sink (input valid, entry_frame_out, present_bit, writable_bit, user_bit,
                entry_changed, out_of_frames, output ready);
endinterface
`default_nettype wire

// ----- sv/pfba_bitmap_ram.sv -----
// pfba_bitmap_ram: frame bitmap memory, one read and one write port, registered read
// per-word valid flops make unwritten words read as all-free; uses pfba_pkg
`default_nettype none
module pfba_bitmap_ram (
  input  wire                            clk,
  input  wire                            rst,
  input  pfba_pkg::ram_req_t             req,
  output logic [pfba_pkg::WORD_BITS-1:0] rd_data
);
  import pfba_pkg::*;

  logic [WORD_BITS-1:0]    mem [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] vld;
  logic [WORD_BITS-1:0]    rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q   <= mem[req.rd_addr];
      rd_vld <= vld[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

// ----- sv/pfba_cfg.sv -----
// pfba_cfg: APB register block holding frames_in_use
// uses pfba_pkg for widths, reset value and register index
`default_nettype none
module pfba_cfg (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [pfba_pkg::PADDR_W-1:0]     paddr,
  input  wire [pfba_pkg::APB_DW-1:0]      pwdata,
  output logic [pfba_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output logic [pfba_pkg::CFG_W-1:0]      frames_in_use
);
  import pfba_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_FRAMES_IN_USE)) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_FRAMES_IN_USE) ? APB_DW'(frames_in_use) : '0;

endmodule
`default_nettype wire

// ----- sv/pfba_ctrl.sv -----
// pfba_ctrl: request sequencer; scans bitmap words one per cycle, read-modify-writes
// the chosen word and holds the response register; uses pfba_pkg and the channel interfaces
`default_nettype none
module pfba_ctrl (
  input  wire                            clk,
  input  wire                            rst,
  input  wire [pfba_pkg::CFG_W-1:0]      frames_in_use,
  pfba_in_if.sink                        req,
  pfba_out_if.source                     rsp,
  output pfba_pkg::ram_req_t             ram_req,
  input  wire [pfba_pkg::WORD_BITS-1:0]  rd_data
);
  import pfba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    logic               changed;
    logic               oof;
  } result_t;

  logic [1:0]         state, state_next;
  logic [WORD_AW-1:0] chk_idx;
  logic [WORD_AW-1:0] free_word;
  logic [BIT_AW-1:0]  free_bit;
  logic               kernel_q;
  logic               wr_q;
  result_t            res, res_new, out_q;
  logic               res_load;
  logic               out_valid;
  logic               out_load;

  logic               accept;
  logic [CFG_W-1:0]   words_full;
  logic [WCNT_W-1:0]  words;
  logic [WCNT_W-1:0]  chk_cnt_next;
  logic [WORD_BITS-1:0] zeros;
  logic               found;
  logic [BIT_AW-1:0]  pos;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // search limit, saturated at the bitmap size
  assign words_full   = frames_in_use >> BIT_AW;
  assign words        = (words_full > CFG_W'(BITMAP_WORDS)) ? WCNT_W'(BITMAP_WORDS)
                                                             : words_full[WCNT_W-1:0];
  assign chk_cnt_next = WCNT_W'(chk_idx) + WCNT_W'(1);

  // lowest clear bit of the word being checked
  assign zeros = ~rd_data;
  assign found = |zeros;
  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (zeros[b]) begin
        pos = BIT_AW'(b);
      end
    end
  end

  always_comb begin
    state_next = state;
    res_new    = '0;
    res_load   = 1'b0;
    out_load   = 1'b0;
    ram_req    = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation == OP_ALLOC) begin
            if (req.entry_frame_in != '0) begin
              res_new.frame = req.entry_frame_in;
              res_load      = 1'b1;
              state_next    = S_EMIT;
            end else if (words == '0) begin
              res_new.oof = 1'b1;
              res_load    = 1'b1;
              state_next  = S_EMIT;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = '0;
              state_next      = S_SCAN;
            end
          end else begin
            if (req.entry_frame_in == '0) begin
              res_load   = 1'b1;
              state_next = S_EMIT;
            end else if (CFG_W'(req.entry_frame_in) >= CFG_W'(MAX_FRAMES)) begin
              res_new.frame = req.entry_frame_in;
              res_load      = 1'b1;
              state_next    = S_EMIT;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = req.entry_frame_in[FRAME_W-1:BIT_AW];
              state_next      = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          ram_req.wr_en    = 1'b1;
          ram_req.wr_addr  = chk_idx;
          ram_req.wr_data  = rd_data | (WORD_BITS'(1) << pos);
          res_new.frame    = FRAME_W'({chk_idx, pos});
          res_new.present  = 1'b1;
          res_new.writable = wr_q;
          res_new.user     = ~kernel_q;
          res_new.changed  = 1'b1;
          res_load         = 1'b1;
          state_next       = S_EMIT;
        end else if (chk_cnt_next == words) begin
          res_new.oof = 1'b1;
          res_load    = 1'b1;
          state_next  = S_EMIT;
        end else begin
          // fetch the next word while this one is being checked
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = chk_cnt_next[WORD_AW-1:0];
        end
      end
      S_FREE: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = free_word;
        ram_req.wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
        res_new.changed = 1'b1;
        res_load        = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kernel_q  <= req.kernel_page;
      wr_q      <= req.writable_request;
      free_word <= req.entry_frame_in[FRAME_W-1:BIT_AW];
      free_bit  <= req.entry_frame_in[BIT_AW-1:0];
      chk_idx   <= '0;
    end else if (state == S_SCAN) begin
      chk_idx <= chk_cnt_next[WORD_AW-1:0];
    end
    if (res_load) begin
      res <= res_new;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.entry_frame_out = out_q.frame;
  assign rsp.present_bit     = out_q.present;
  assign rsp.writable_bit    = out_q.writable;
  assign rsp.user_bit        = out_q.user;
  assign rsp.entry_changed   = out_q.changed;
  assign rsp.out_of_frames   = out_q.oof;

endmodule
`default_nettype wire

// ----- sv/page_frame_bitmap_allocator.sv -----
// page_frame_bitmap_allocator: first-fit page frame allocator over a 128-word bitmap.
// A request needing no bitmap access goes straight to the response register; a free reads
// its word and writes it back; an allocation scans words from word 0 until a clear bit.
// One request is in flight at a time; the single bitmap read port scans one word per
// cycle. A new request is taken while the previous response waits.
// Synchronous reset: all frames free (per-word valid flops), frames_in_use = 4096.
`default_nettype none
module page_frame_bitmap_allocator (
  input  wire                          clk,
  input  wire                          rst,
  pfba_in_if.sink                      req,
  pfba_out_if.source                   rsp,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [pfba_pkg::PADDR_W-1:0]  paddr,
  input  wire [pfba_pkg::APB_DW-1:0]   pwdata,
  output logic [pfba_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import pfba_pkg::*;

  logic [CFG_W-1:0]     frames_in_use;
  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] rd_data;

  pfba_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frames_in_use (frames_in_use)
  );

  pfba_bitmap_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  pfba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_in_use),
    .req           (req),
    .rsp           (rsp),
    .ram_req       (ram_req),
    .rd_data       (rd_data)
  );

endmodule
`default_nettype wire

// ----- sv/pfba_checker.sv -----
// pfba_checker: port-level assertions for the allocator, bound to the top level
// uses pfba_pkg for field widths
`default_nettype none
module pfba_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          rsp_valid,
  input wire                          rsp_ready,
  input wire [pfba_pkg::FRAME_W-1:0]  entry_frame_out,
  input wire                          present_bit,
  input wire                          writable_bit,
  input wire                          user_bit,
  input wire                          entry_changed,
  input wire                          out_of_frames
);
  import pfba_pkg::*;

  // a stalled response beat keeps its frame, present, changed and out_of_frames fields
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_frame_out)
      && $stable(present_bit) && $stable(entry_changed) && $stable(out_of_frames))
    else $error("response payload changed while stalled");

  // a failed allocation touches nothing and returns frame 0
  a_oof_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_of_frames |-> entry_frame_out == '0 && !entry_changed
      && !present_bit && !writable_bit && !user_bit)
    else $error("out_of_frames with other fields set");

  // page flags only come with a successful allocation
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (present_bit || writable_bit || user_bit) |-> present_bit && entry_changed)
    else $error("page flags without allocation");

  // a successful free returns an empty entry
  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && entry_changed && !present_bit |-> entry_frame_out == '0)
    else $error("free returned nonzero frame");

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .entry_frame_out (rsp.entry_frame_out),
  .present_bit     (rsp.present_bit),
  .writable_bit    (rsp.writable_bit),
  .user_bit        (rsp.user_bit),
  .entry_changed   (rsp.entry_changed),
  .out_of_frames   (rsp.out_of_frames)
);
`default_nettype wire

// ----- bench/pfba_frame_checker.sv -----
// pfba_frame_checker: watches the request, response and apb ports of the frame allocator,
// predicts each response from its own bitmap copy and compares field by field
// depends on pfba_pkg and the pfba_in_if / pfba_out_if interfaces
`default_nettype none
module pfba_frame_checker (
  input  wire                          clk,
  input  wire                          rst,
  pfba_in_if                           req,
  pfba_out_if                          rsp,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [pfba_pkg::PADDR_W-1:0]  paddr,
  input  wire [pfba_pkg::APB_DW-1:0]   pwdata,
  input  wire                          pready,
  output int                           fail_count,
  output int                           outstanding
);
  import pfba_pkg::*;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    logic               changed;
    logic               oof;
  } frame_rsp_t;

  logic [WORD_BITS-1:0] frame_map [BITMAP_WORDS];
  logic [CFG_W-1:0]     frames_cfg;
  frame_rsp_t           expected_rsp_q [$];
  int                   mismatch_total;

  assign fail_count = mismatch_total;

  // first-fit search over whole words below frames_cfg, updates the bitmap copy
  function automatic frame_rsp_t predict_frame_response(logic op, logic [FRAME_W-1:0] entry,
                                                        logic kernel, logic wr);
    frame_rsp_t r;
    int         words;
    int         hit;
    int         w;
    int         b;
    r = '0;
    if (op == OP_ALLOC) begin
      if (entry != '0) begin
        r.frame = entry;
      end else begin
        words = int'(frames_cfg) / WORD_BITS;
        if (words > BITMAP_WORDS) words = BITMAP_WORDS;
        hit = -1;
        for (w = 0; w < words && hit < 0; w++) begin
          for (b = 0; b < WORD_BITS && hit < 0; b++) begin
            if (!frame_map[w][b]) hit = w * WORD_BITS + b;
          end
        end
        if (hit < 0) begin
          r.oof = 1'b1;
        end else begin
          frame_map[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
          r.frame    = FRAME_W'(hit);
          r.present  = 1'b1;
          r.writable = wr;
          r.user     = ~kernel;
          r.changed  = 1'b1;
        end
      end
    end else if (entry != '0) begin
      // free ignores frames_cfg
      frame_map[int'(entry) / WORD_BITS][int'(entry) % WORD_BITS] = 1'b0;
      r.changed = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      mismatch_total++;
    end
  endtask

  initial mismatch_total = 0;

  always @(posedge clk) begin
    frame_rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < BITMAP_WORDS; i++) frame_map[i] = '0;
      frames_cfg = FRAMES_RESET;
      expected_rsp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_FRAMES_IN_USE) begin
        frames_cfg = pwdata[CFG_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response beat with nothing expected, got frame %0h",
                   $time, rsp.entry_frame_out);
          mismatch_total++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("entry_frame_out", exp_rsp.frame, rsp.entry_frame_out);
          check_field("present_bit", exp_rsp.present, rsp.present_bit);
          check_field("writable_bit", exp_rsp.writable, rsp.writable_bit);
          check_field("user_bit", exp_rsp.user, rsp.user_bit);
          check_field("entry_changed", exp_rsp.changed, rsp.entry_changed);
          check_field("out_of_frames", exp_rsp.oof, rsp.out_of_frames);
        end
      end
      if (req.valid && req.ready) begin
        expected_rsp_q.push_back(predict_frame_response(req.operation, req.entry_frame_in,
                                                        req.kernel_page,
                                                        req.writable_request));
      end
    end
    outstanding <= expected_rsp_q.size();
  end

endmodule
`default_nettype wire

// ----- bench/tb_page_frame_bitmap_allocator.sv -----
// tb_page_frame_bitmap_allocator: stimulus and verdict for the frame allocator,
// directed corner cases then random alloc/free traffic over several frames_in_use settings
// depends on pfba_pkg, the pfba interfaces, pfba_frame_checker and the allocator rtl
`default_nettype none
module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 92;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(1);

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  int                   fail_count;
  int                   outstanding;
  int                   idle_cycles;
  bit                   quiet_tail;
  logic [FRAME_W-1:0]   held_frames [$];

  int unsigned phase_cfg [NUM_PHASES] = '{64, 32, 31, 96, 4096, 8191, 40, 128, 1024};

  pfba_in_if  req_ch ();
  pfba_out_if rsp_ch ();

  page_frame_bitmap_allocator u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pfba_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frames handed out, so frees can target live mappings
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.entry_changed && rsp_ch.present_bit)
      held_frames.push_back(rsp_ch.entry_frame_out);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("page_frame_bitmap_allocator regression: fail");
        $finish;
      end
    end
  end

  // response backpressure in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) rsp_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 6);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold off until every response is back and the block has settled
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_request(logic op, logic [FRAME_W-1:0] frame, logic kernel, logic wr);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.operation        <= op;
    req_ch.entry_frame_in   <= frame;
    req_ch.kernel_page      <= kernel;
    req_ch.writable_request <= wr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_random_request();
    int                 pick;
    int                 idx;
    logic               op;
    logic [FRAME_W-1:0] frame;
    pick = $urandom_range(0, 99);
    op    = OP_ALLOC;
    frame = '0;
    if (pick >= 50 && pick < 80 && held_frames.size() > 0) begin
      idx   = $urandom_range(0, held_frames.size() - 1);
      op    = OP_FREE;
      frame = held_frames[idx];
      held_frames.delete(idx);
    end else if (pick >= 80 && pick < 87) begin
      frame = FRAME_W'($urandom_range(1, 4095));
    end else if (pick >= 87 && pick < 95) begin
      op    = OP_FREE;
      frame = FRAME_W'($urandom_range(1, 4095));
    end else if (pick >= 95) begin
      op = OP_FREE;
    end
    send_request(op, frame, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    quiet_tail = 1'b0;
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.operation        <= OP_ALLOC;
    req_ch.entry_frame_in   <= '0;
    req_ch.kernel_page      <= 1'b0;
    req_ch.writable_request <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: frame zero is handed out first
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b0);
    send_request(OP_ALLOC, 12'hfff, 1'b0, 1'b1);  // entry already mapped
    send_request(OP_ALLOC, 12'd1, 1'b1, 1'b1);
    send_request(OP_FREE, 12'd0, 1'b1, 1'b1);     // empty entry
    send_request(OP_FREE, 12'd1, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b0);
    send_request(OP_FREE, 12'hfff, 1'b0, 1'b0);
    send_request(OP_FREE, 12'haaa, 1'b1, 1'b0);
    send_request(OP_FREE, 12'h555, 1'b0, 1'b1);

    // no words searched: allocation runs dry, free still works
    wait_drained();
    apb_write(REG_FRAMES_IN_USE, 32'd0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
    send_request(OP_FREE, 12'd1, 1'b0, 1'b0);
    wait_drained();
    apb_write(REG_UNMAPPED, 32'd4096);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);

    // all ones: upper bits dropped, search saturates at the full bitmap
    wait_drained();
    apb_write(REG_FRAMES_IN_USE, 32'hffff_ffff);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      apb_write(REG_FRAMES_IN_USE, phase_cfg[p]);
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("page_frame_bitmap_allocator regression: pass");
    end else begin
      $display("page_frame_bitmap_allocator regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
